// ===== rtl/tdc_pkg.sv =====
`default_nettype none

package tdc_pkg;

  localparam int unsigned HdrLen = 9;
  localparam int unsigned HdrIdxW = $clog2(HdrLen + 1);
  localparam int unsigned KeyLen = 16;
  localparam int unsigned KeyIdxW = $clog2(KeyLen);

  localparam logic [7:0] DecodeLo = 8'd33;
  localparam logic [7:0] DecodeHi = 8'd127;
  localparam logic [7:0] WrapAdd = 8'd95;
  localparam logic [7:0] CaseShift = 8'd32;
  localparam logic [1:0] AngleMax = 2'd3;

  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChLt = 8'h3c;
  localparam logic [7:0] ChGt = 8'h3e;
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpZ = 8'h5a;

  // header text, lower case
  localparam logic [7:0] HdrText [HdrLen] = '{
    8'h72, 8'h65, 8'h64, 8'h73, 8'h68, 8'h69, 8'h72, 8'h74, 8'h32
  };

  localparam logic [7:0] KeyTable [KeyLen] = '{
    8'd31, 8'd7, 8'd9, 8'd1, 8'd11, 8'd2, 8'd5, 8'd5,
    8'd3, 8'd17, 8'd40, 8'd12, 8'd35, 8'd22, 8'd27, 8'd2
  };

  typedef enum logic [1:0] {
    ModeUndecided = 2'd0,
    ModePlain     = 2'd1,
    ModeEncrypted = 2'd2
  } mode_e;

  typedef struct packed {
    logic [KeyIdxW-1:0] key;
    logic [1:0]         angle;
    logic               comm;
    logic               err;
  } rule_st_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       line_done;
    logic       run_last;
    logic       encrypted_mode;
    logic       merge_error;
  } res_t;

  function automatic logic [7:0] lower_ascii(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= ChUpA && c <= ChUpZ) begin
      r = c + CaseShift;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tdc_in_if.sv =====
`default_nettype none

interface tdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       line_end;

  modport source (output valid, output data_byte, output line_end, input ready);
  modport sink (input valid, input data_byte, input line_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdc_out_if.sv =====
`default_nettype none

interface tdc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       line_done;
  logic       run_last;
  logic       encrypted_mode;
  logic       merge_error;

  modport source (
    output valid, output out_byte, output has_byte, output line_done,
    output run_last, output encrypted_mode, output merge_error, input ready
  );
  modport sink (
    input valid, input out_byte, input has_byte, input line_done,
    input run_last, input encrypted_mode, input merge_error, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tdc_byte_unit.sv =====
`default_nettype none

module tdc_byte_unit (
  input  wire logic [7:0]       byte_i,
  input  wire logic             decode_i,
  input  wire tdc_pkg::rule_st_t st_i,
  output tdc_pkg::rule_st_t     st_o,
  output logic [7:0]            byte_o,
  output logic                  kept_o
);
  import tdc_pkg::*;

  logic [KeyIdxW-1:0] key_nxt;
  logic [7:0]         tab;
  logic [7:0]         b;

  assign key_nxt = st_i.key + KeyIdxW'(1);
  assign tab     = KeyTable[key_nxt];

  always_comb begin
    st_o   = st_i;
    b      = byte_i;
    kept_o = 1'b0;
    // decode printable range, key steps first
    if (decode_i && byte_i >= DecodeLo && byte_i <= DecodeHi) begin
      st_o.key = key_nxt;
      if (byte_i < tab + DecodeLo) begin
        b = byte_i + WrapAdd - tab;
      end else begin
        b = byte_i - tab;
      end
    end
    if (!st_i.comm) begin
      if (b == ChLt || b == ChGt) begin
        if (st_i.angle < AngleMax) begin
          st_o.angle = st_i.angle + 2'd1;
        end
        if (st_o.angle == AngleMax) begin
          st_o.err = 1'b1;
        end
        kept_o = 1'b1;
      end else begin
        st_o.angle = '0;
        if (b == ChHash) begin
          st_o.comm = 1'b1;
        end else begin
          kept_o = 1'b1;
        end
      end
    end
    byte_o = b;
  end

endmodule

`default_nettype wire

// ===== rtl/tdc_out_buf.sv =====
`default_nettype none

module tdc_out_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tdc_pkg::res_t res_i,
  output logic               space_o,
  output logic               valid_o,
  input  wire logic          ready_i,
  output tdc_pkg::res_t      res_o
);
  import tdc_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign pop     = valid_o && ready_i;
  assign res_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tdc_ctrl.sv =====
`default_nettype none

module tdc_ctrl (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic [7:0] in_data_byte_i,
  input  wire logic     in_line_end_i,
  output logic          in_ready_o,
  input  wire logic     space_i,
  output logic          push_o,
  output tdc_pkg::res_t res_o
);
  import tdc_pkg::*;

  // input register
  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_le_q;
  logic       a_take, in_fire;

  mode_e              mode_q, mode_d;
  logic [HdrIdxW-1:0] hc_q, hc_d;
  logic [7:0]         hold_q [HdrLen];
  logic               hold_we;
  rule_st_t           st_q, st_d;

  // header flush sequencer
  logic               flush_q, flush_d;
  logic [HdrIdxW-1:0] fidx_q, fidx_d;
  logic [HdrIdxW-1:0] fcnt_q, fcnt_d;
  logic               fle_q, fle_d;
  logic               pend_valid_q, pend_valid_d;
  logic [7:0]         pend_byte_q, pend_byte_d;
  logic               pend_err_q, pend_err_d;

  logic [7:0] hold_rd, unit_byte, unit_out;
  logic       unit_decode, unit_kept;
  rule_st_t   unit_st;
  logic       hdr_match, decide;

  assign a_take     = a_valid_q && !flush_q && space_i;
  assign in_ready_o = !a_valid_q || a_take;
  assign in_fire    = in_valid_i && in_ready_o;

  assign hold_rd     = (fidx_q < HdrIdxW'(HdrLen)) ? hold_q[fidx_q] : '0;
  assign unit_byte   = flush_q ? hold_rd : a_byte_q;
  assign unit_decode = !flush_q && (mode_q == ModeEncrypted);

  tdc_byte_unit u_byte_unit (
    .byte_i  (unit_byte),
    .decode_i(unit_decode),
    .st_i    (st_q),
    .st_o    (unit_st),
    .byte_o  (unit_out),
    .kept_o  (unit_kept)
  );

  assign decide = (hc_q == HdrIdxW'(HdrLen - 1)) || a_le_q;

  always_comb begin
    hdr_match = (hc_q == HdrIdxW'(HdrLen - 1))
             && (lower_ascii(a_byte_q) == HdrText[HdrLen-1]);
    for (int i = 0; i < HdrLen - 1; i++) begin
      if (lower_ascii(hold_q[i]) != HdrText[i]) begin
        hdr_match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_d       = mode_q;
    hc_d         = hc_q;
    hold_we      = 1'b0;
    st_d         = st_q;
    flush_d      = flush_q;
    fidx_d       = fidx_q;
    fcnt_d       = fcnt_q;
    fle_d        = fle_q;
    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;
    pend_err_d   = pend_err_q;
    push_o       = 1'b0;
    res_o        = '0;

    if (flush_q && space_i) begin
      if (fidx_q < fcnt_q) begin
        st_d   = unit_st;
        fidx_d = fidx_q + HdrIdxW'(1);
        if (unit_kept) begin
          if (pend_valid_q) begin
            push_o            = 1'b1;
            res_o.out_byte    = pend_byte_q;
            res_o.has_byte    = 1'b1;
            res_o.merge_error = pend_err_q;
          end
          pend_valid_d = 1'b1;
          pend_byte_d  = unit_out;
          pend_err_d   = unit_st.err;
        end
      end else begin
        // closing step: last kept byte or bare marker
        if (pend_valid_q) begin
          push_o            = 1'b1;
          res_o.out_byte    = pend_byte_q;
          res_o.has_byte    = 1'b1;
          res_o.line_done   = fle_q;
          res_o.run_last    = 1'b1;
          res_o.merge_error = pend_err_q;
        end else if (fle_q) begin
          push_o            = 1'b1;
          res_o.line_done   = 1'b1;
          res_o.run_last    = 1'b1;
          res_o.merge_error = st_q.err;
        end
        if (fle_q) begin
          st_d.angle = '0;
          st_d.comm  = 1'b0;
        end
        flush_d      = 1'b0;
        pend_valid_d = 1'b0;
      end
    end else if (a_take) begin
      unique case (mode_q)
        ModeUndecided: begin
          hold_we = 1'b1;
          if (!decide) begin
            hc_d = hc_q + HdrIdxW'(1);
          end else begin
            hc_d = '0;
            if (hdr_match) begin
              mode_d = ModeEncrypted;
              if (a_le_q) begin
                push_o               = 1'b1;
                res_o.line_done      = 1'b1;
                res_o.run_last       = 1'b1;
                res_o.encrypted_mode = 1'b1;
                res_o.merge_error    = st_q.err;
              end
            end else begin
              mode_d  = ModePlain;
              flush_d = 1'b1;
              fidx_d  = '0;
              fcnt_d  = hc_q + HdrIdxW'(1);
              fle_d   = a_le_q;
            end
          end
        end
        default: begin
          st_d = unit_st;
          if (a_le_q) begin
            st_d.angle = '0;
            st_d.comm  = 1'b0;
          end
          if (unit_kept || a_le_q) begin
            push_o               = 1'b1;
            res_o.out_byte       = unit_kept ? unit_out : '0;
            res_o.has_byte       = unit_kept;
            res_o.line_done      = a_le_q;
            res_o.run_last       = 1'b1;
            res_o.encrypted_mode = (mode_q == ModeEncrypted);
            res_o.merge_error    = unit_st.err;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      mode_q       <= ModeUndecided;
      hc_q         <= '0;
      st_q         <= '0;
      flush_q      <= 1'b0;
      fidx_q       <= '0;
      fcnt_q       <= '0;
      fle_q        <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid_q <= 1'b1;
      end else if (a_take) begin
        a_valid_q <= 1'b0;
      end
      mode_q       <= mode_d;
      hc_q         <= hc_d;
      st_q         <= st_d;
      flush_q      <= flush_d;
      fidx_q       <= fidx_d;
      fcnt_q       <= fcnt_d;
      fle_q        <= fle_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_byte_q <= in_data_byte_i;
      a_le_q   <= in_line_end_i;
    end
    if (hold_we) begin
      hold_q[hc_q] <= a_byte_q;
    end
    pend_byte_q <= pend_byte_d;
    pend_err_q  <= pend_err_d;
  end

endmodule

`default_nettype wire

// ===== rtl/text_line_decrypt_and_clean.sv =====
// text line decrypt and clean
// in_i takes one byte of a text file per transfer, line_end set on the last
// byte of each line. out_o gives the kept bytes, one per transfer, plus a
// bare line marker (has_byte low) for a line end that keeps nothing.
// a byte passes the input register and a two-entry result buffer to out_o.
// throughput: one byte per cycle while out_o takes results and no header
// replay runs, set by the single byte rule unit that decodes and applies
// the comment and bracket rules in one pass.
// the first up to nine bytes of the file are held while the header is
// checked and give no transfer; with no header match they are replayed
// through the rule unit one per cycle while out_o takes results, and in_i
// is held off during the replay and its closing step, once per file.
// a stall on out_o fills the result buffer and then the input register,
// after which in_i.ready drops; nothing is lost or repeated.
// reset clears mode, key index, bracket run, comment and error flags and
// empties both registers; no clearing pass is needed.
`default_nettype none

module text_line_decrypt_and_clean (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tdc_in_if.sink    in_i,
  tdc_out_if.source out_o
);
  import tdc_pkg::*;

  logic push, space;
  res_t push_res, head_res;

  // header check, key decode and line rules
  tdc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_data_byte_i(in_i.data_byte),
    .in_line_end_i (in_i.line_end),
    .in_ready_o    (in_i.ready),
    .space_i       (space),
    .push_o        (push),
    .res_o         (push_res)
  );

  // result buffer parts the two sides
  tdc_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res_i  (push_res),
    .space_o(space),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .res_o  (head_res)
  );

  assign out_o.out_byte       = head_res.out_byte;
  assign out_o.has_byte       = head_res.has_byte;
  assign out_o.line_done      = head_res.line_done;
  assign out_o.run_last       = head_res.run_last;
  assign out_o.encrypted_mode = head_res.encrypted_mode;
  assign out_o.merge_error    = head_res.merge_error;

endmodule

`default_nettype wire

// ===== rtl/tdc_checker.sv =====
`default_nettype none

module tdc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       has_byte_i,
  input wire logic       line_done_i,
  input wire logic       run_last_i,
  input wire logic       encrypted_mode_i,
  input wire logic       merge_error_i
);

  logic xfer;
  logic err_seen_q, enc_seen_q;

  assign xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
      enc_seen_q <= 1'b0;
    end else if (xfer) begin
      if (merge_error_i) begin
        err_seen_q <= 1'b1;
      end
      if (encrypted_mode_i) begin
        enc_seen_q <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && err_seen_q |-> merge_error_i)
    else $error("merge error flag cleared");

  a_enc_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && enc_seen_q |-> encrypted_mode_i)
    else $error("encrypted mode left");

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !has_byte_i |-> out_byte_i == 8'd0 && line_done_i && run_last_i)
    else $error("malformed bare line marker");

  a_line_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && line_done_i |-> run_last_i)
    else $error("line end not on last result of item");

endmodule

bind text_line_decrypt_and_clean tdc_checker u_tdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_byte_i      (out_o.out_byte),
  .has_byte_i      (out_o.has_byte),
  .line_done_i     (out_o.line_done),
  .run_last_i      (out_o.run_last),
  .encrypted_mode_i(out_o.encrypted_mode),
  .merge_error_i   (out_o.merge_error)
);

`default_nettype wire
